[src/pgb_pkg.sv]
// shared constants and functions for the phong specular evaluator
package pgb_pkg;

    localparam int VEC_FRAC_BITS_DEF = 14;
    localparam int LOG_STEPS = 16;

    // register indexes
    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_RED   = 3'd1;
    localparam logic [2:0] REG_GREEN = 3'd2;
    localparam logic [2:0] REG_BLUE  = 3'd3;
    localparam logic [2:0] REG_EXP   = 3'd4;

    // floor square root, bit by bit from the top pair of bits
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res, bitv, rem;
        res = '0;
        rem = v;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q0.30 by repeated floor square roots of 2^-1
    function automatic logic [29:0] exp2_coef(int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 1; j < k; j++)
            c = isqrt64(c << 30);
        return c[29:0];
    endfunction

    // 2^(-2^-k) in Q0.30, k = 1..16, index k-1
    localparam logic [29:0] EXP2_TAB [16] = '{
        exp2_coef(1), exp2_coef(2), exp2_coef(3), exp2_coef(4),
        exp2_coef(5), exp2_coef(6), exp2_coef(7), exp2_coef(8),
        exp2_coef(9), exp2_coef(10), exp2_coef(11), exp2_coef(12),
        exp2_coef(13), exp2_coef(14), exp2_coef(15), exp2_coef(16)
    };

    typedef struct packed {
        logic        valid;
        logic        zero;   // result forced to zero
        logic        one;    // power exactly one
        logic        under;  // power zero
    } t_flags;

endpackage

[src/phong_glossy_brdf_eval_unit.sv]
// phong specular brdf evaluation pipeline
//
// Usage: drive the nine Q(2.F) vector fields with i_start high while
// o_busy is low; o_busy is always low, so one word is taken every cycle.
// Each result word appears on o_radiance_* for one cycle with o_done high.
// From accept to o_done a word passes the n.wi product, dq, reflection
// and c product stages, 1 base/normalize stage, 16 log2 squaring stages
// (one 31x31 square per stage), 1 exponent multiply, 16 exp2 stages (one
// 31x30 multiply per stage), 1 final shift, and the gain, colour product
// and sum/saturate stages. Throughput is one word per cycle, set by the
// fully pipelined squaring and exp2 chains.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; unknown
// indexes are ignored. Write only while no word is in flight.
// Reset (i_rst_n low, synchronous) restores the register defaults and
// clears all valid bits. The receiver cannot stall: results are
// presented exactly once and must be taken.
module phong_glossy_brdf_eval_unit #(
    parameter int VEC_FRAC_BITS = pgb_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_in_dir_x,
    input  logic signed [15:0] i_in_dir_y,
    input  logic signed [15:0] i_in_dir_z,
    input  logic signed [15:0] i_out_dir_x,
    input  logic signed [15:0] i_out_dir_y,
    input  logic signed [15:0] i_out_dir_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_done,
    output logic [15:0]        o_radiance_red,
    output logic [15:0]        o_radiance_green,
    output logic [15:0]        o_radiance_blue
);
    import pgb_pkg::*;

    localparam int F   = VEC_FRAC_BITS;
    localparam int SH  = 2 * F - 16;
    // c is below 3 * 2^35 * 2^17 bounds; keep 56 bits signed
    localparam int CW  = 56;

    // configuration registers
    logic [15:0] r_gain, r_red, r_green, r_blue, r_exp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd0;
            r_red <= 16'hFFFF;
            r_green <= 16'hFFFF;
            r_blue <= 16'hFFFF;
            r_exp <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN:  r_gain <= i_cfg_data;
                REG_RED:   r_red <= i_cfg_data;
                REG_GREEN: r_green <= i_cfg_data;
                REG_BLUE:  r_blue <= i_cfg_data;
                REG_EXP:   r_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;
    logic w_acc;
    assign w_acc = i_start && !o_busy;

    // stage 1: n.wi products, register inputs
    logic        r1_v;
    logic signed [31:0] r1_p [3];
    logic signed [15:0] r1_n [3], r1_wi [3], r1_wo [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= w_acc;
        r1_p[0] <= i_normal_x * i_in_dir_x;
        r1_p[1] <= i_normal_y * i_in_dir_y;
        r1_p[2] <= i_normal_z * i_in_dir_z;
        r1_n[0] <= i_normal_x; r1_n[1] <= i_normal_y; r1_n[2] <= i_normal_z;
        r1_wi[0] <= i_in_dir_x; r1_wi[1] <= i_in_dir_y; r1_wi[2] <= i_in_dir_z;
        r1_wo[0] <= i_out_dir_x; r1_wo[1] <= i_out_dir_y; r1_wo[2] <= i_out_dir_z;
    end

    // stage 2: dq = floor(d / 2^F)
    logic r2_v;
    logic signed [33:0] r2_dq;
    logic signed [33:0] n_d;
    logic signed [15:0] r2_n [3], r2_wi [3], r2_wo [3];
    assign n_d = 34'(r1_p[0]) + 34'(r1_p[1]) + 34'(r1_p[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_dq <= n_d >>> F;
        r2_n <= r1_n; r2_wi <= r1_wi; r2_wo <= r1_wo;
    end

    // stage 3: rq_i = floor((2 n_i dq - wi_i 2^F) / 2^F)
    logic r3_v;
    logic signed [51:0] r3_rq [3];
    logic signed [15:0] r3_wo [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        for (int i = 0; i < 3; i++) begin
            r3_rq[i] <= ((52'(r2_n[i]) * 52'(r2_dq) * 52'sd2)
                        - (52'(r2_wi[i]) <<< F)) >>> F;
        end
        r3_wo <= r2_wo;
    end

    // stage 4: c products (rq fits 34 bits for 16-bit inputs)
    logic r4_v;
    logic signed [CW-1:0] r4_cp [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= r3_v;
        for (int i = 0; i < 3; i++)
            r4_cp[i] <= CW'(r3_rq[i]) * CW'(r3_wo[i]);
    end

    // stage 5: sum, base, classify, normalize
    logic signed [CW-1:0] n_c;
    logic [CW-1:0] n_b;
    logic [4:0]  n_p;
    logic [30:0] n_m;
    assign n_c = r4_cp[0] + r4_cp[1] + r4_cp[2];
    always_comb begin
        if (SH >= 0) n_b = CW'(n_c >>> SH);
        else n_b = CW'(n_c <<< (-SH));
        n_p = 5'd0;
        for (int k = 0; k < 16; k++)
            if (n_b[k]) n_p = 5'(k);
        n_m = 31'(n_b[15:0]) << (5'd30 - n_p);
    end
    t_flags r5_f;
    logic [4:0] r5_p;
    logic [30:0] r5_m;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_f.valid <= 1'b0;
        else r5_f.valid <= r4_v;
        r5_f.zero  <= (n_c <= 0);
        r5_f.one   <= (n_b >= CW'(65536)) || (n_b == '0 && r_exp == 16'd0);
        r5_f.under <= (n_b == '0);
        r5_p <= n_p;
        r5_m <= n_m;
    end

    // log2 stages: one square and compare per stage
    t_flags r_lf [LOG_STEPS+1];
    logic [30:0] r_lm [LOG_STEPS+1];
    logic [15:0] r_lfr [LOG_STEPS+1];
    logic [4:0]  r_lp [LOG_STEPS+1];
    always_comb begin
        r_lf[0] = r5_f; r_lm[0] = r5_m; r_lfr[0] = '0; r_lp[0] = r5_p;
    end
    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        logic [61:0] w_sq;
        logic [31:0] w_m;
        assign w_sq = 62'(r_lm[g]) * 62'(r_lm[g]);
        assign w_m = 32'(w_sq >> 30);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_lf[g+1].valid <= 1'b0;
            else r_lf[g+1].valid <= r_lf[g].valid;
            r_lf[g+1].zero <= r_lf[g].zero;
            r_lf[g+1].one <= r_lf[g].one;
            r_lf[g+1].under <= r_lf[g].under;
            r_lp[g+1] <= r_lp[g];
            r_lfr[g+1] <= {r_lfr[g][14:0], w_m[31]};
            r_lm[g+1] <= w_m[31] ? 31'(w_m >> 1) : w_m[30:0];
        end
    end

    // t = floor(L * exp / 256)
    logic [20:0] n_l;
    logic [36:0] n_t;
    assign n_l = 21'(5'd16 - r_lp[LOG_STEPS]) * 21'd65536 - 21'(r_lfr[LOG_STEPS]);
    assign n_t = 37'(n_l) * 37'(r_exp);
    t_flags r6_f;
    logic [28:0] r6_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_f.valid <= 1'b0;
        else r6_f.valid <= r_lf[LOG_STEPS].valid;
        r6_f.zero <= r_lf[LOG_STEPS].zero;
        r6_f.one <= r_lf[LOG_STEPS].one;
        r6_f.under <= r_lf[LOG_STEPS].under;
        r6_t <= n_t[36:8];
    end

    // exp2 stages: one constant multiply per fraction bit
    t_flags r_ef [LOG_STEPS+1];
    logic [30:0] r_ea [LOG_STEPS+1];
    logic [28:0] r_et [LOG_STEPS+1];
    always_comb begin
        r_ef[0] = r6_f; r_ea[0] = 31'd1 << 30; r_et[0] = r6_t;
    end
    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_exp
        logic [60:0] w_pr;
        assign w_pr = 61'(r_ea[g]) * 61'(EXP2_TAB[g]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_ef[g+1].valid <= 1'b0;
            else r_ef[g+1].valid <= r_ef[g].valid;
            r_ef[g+1].zero <= r_ef[g].zero;
            r_ef[g+1].one <= r_ef[g].one;
            r_ef[g+1].under <= r_ef[g].under;
            r_et[g+1] <= r_et[g];
            r_ea[g+1] <= r_et[g][15-g] ? 31'(w_pr >> 30) : r_ea[g];
        end
    end

    // power select and integer shift
    logic r7_v;
    logic [30:0] r7_pw;
    logic [12:0] w_ip;
    assign w_ip = r_et[LOG_STEPS][28:16];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else r7_v <= r_ef[LOG_STEPS].valid;
        priority if (r_ef[LOG_STEPS].zero) r7_pw <= '0;
        else if (r_ef[LOG_STEPS].one) r7_pw <= 31'd1 << 30;
        else if (r_ef[LOG_STEPS].under) r7_pw <= '0;
        else if (w_ip > 13'd30) r7_pw <= '0;
        else r7_pw <= r_ea[LOG_STEPS] >> w_ip[4:0];
    end

    // gain stage: ks * pw
    logic r8_v;
    logic [46:0] r8_g;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else r8_v <= r7_v;
        r8_g <= 47'(r_gain) * 47'(r7_pw);
    end

    // colour products, split 47x16 into two partial products
    logic r9_v;
    logic [46:0] r9_lo [3];
    logic [39:0] r9_hi [3];
    logic [15:0] w_cs [3];
    assign w_cs[0] = r_red; assign w_cs[1] = r_green; assign w_cs[2] = r_blue;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else r9_v <= r8_v;
        for (int i = 0; i < 3; i++) begin
            r9_lo[i] <= 47'(r8_g[23:0]) * 47'(w_cs[i]);
            r9_hi[i] <= 40'(r8_g[46:24]) * 40'(w_cs[i]);
        end
    end

    // sum, shift by 46 and saturate
    logic r10_v;
    logic [15:0] r10_o [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else r10_v <= r9_v;
        for (int i = 0; i < 3; i++) begin
            logic [63:0] s;
            s = (64'(r9_hi[i]) << 24) + 64'(r9_lo[i]);
            r10_o[i] <= (s[63:46] > 18'd65535) ? 16'hFFFF : s[61:46];
        end
    end

    assign o_done = r10_v;
    assign o_radiance_red = r10_o[0];
    assign o_radiance_green = r10_o[1];
    assign o_radiance_blue = r10_o[2];

endmodule

[src/pgb_checker.sv]
// port-level checker for the phong specular evaluator
module pgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done
);
    localparam int LAT = 42;

    // result strobe follows an accepted word after the pipeline latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result without matching accept");

    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("accepted word lost");

    // the pipeline never blocks input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("strobe right after reset");

endmodule

bind phong_glossy_brdf_eval_unit pgb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done)
);
